@@ hw/rtl/mtbt_pkg.sv @@
// Shared types, codes and defaults for the token bucket table.
`timescale 1ns / 1ps
`default_nettype none

package mtbt_pkg;

    localparam int BUCKETS_DEF    = 64;
    localparam int TOKEN_BITS_DEF = 16;

    localparam int KIND_W   = 2;
    localparam int BUCKET_W = 6;
    localparam int FIELD_W  = 16;
    localparam int STATUS_W = 2;

    // free-slot search works on groups of this many slots
    localparam int GROUP   = 16;
    localparam int GROUP_W = $clog2(GROUP);

    localparam int QUEUE_DEPTH = 2;

    localparam logic [KIND_W-1:0] KIND_CREATE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FETCH  = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        OP_CREATE,
        OP_DELETE,
        OP_TICK,
        OP_FETCH
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CREATE,
        S_FETCH,
        S_TICK,
        S_HOLD
    } state_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [BUCKET_W-1:0] bucket;
        logic [FIELD_W-1:0]  fill_rate;
        logic [FIELD_W-1:0]  burst_cap;
        logic [FIELD_W-1:0]  request;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BUCKET_W-1:0] slot;
        logic [FIELD_W-1:0]  granted;
    } out_item_t;

    // decoded request as it sits in the queue
    typedef struct packed {
        op_t                 op;
        logic                in_range;
        logic [BUCKET_W-1:0] bucket;
        logic [FIELD_W-1:0]  fill_rate;
        logic [FIELD_W-1:0]  burst_cap;
        logic [FIELD_W-1:0]  request;
    } work_t;

endpackage

`default_nettype wire

@@ hw/rtl/mtbt_chan_if.sv @@
// Valid/ready channel carrying one payload per request.
`timescale 1ns / 1ps
`default_nettype none

interface mtbt_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
    modport mon    (input valid, input payload, input ready);
endinterface

`default_nettype wire

@@ hw/rtl/mtbt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mtbt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/mtbt_front.sv @@
// Front end: accept requests, decode them and queue them for the back end.
`timescale 1ns / 1ps
`default_nettype none

module mtbt_front #(
    parameter int BUCKETS = mtbt_pkg::BUCKETS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mtbt_chan_if.sink   cmd,
    mtbt_chan_if.source work
);

    localparam int PTR_W = (mtbt_pkg::QUEUE_DEPTH > 1) ? $clog2(mtbt_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(mtbt_pkg::QUEUE_DEPTH + 1);

    mtbt_pkg::work_t  entry_reg [mtbt_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    mtbt_pkg::work_t  decoded;
    logic             push, pop;

    // classify the request
    always_comb
    begin
        decoded.op = mtbt_pkg::OP_TICK;
        unique case (cmd.payload.kind)
            mtbt_pkg::KIND_CREATE: decoded.op = mtbt_pkg::OP_CREATE;
            mtbt_pkg::KIND_DELETE: decoded.op = mtbt_pkg::OP_DELETE;
            mtbt_pkg::KIND_TICK:   decoded.op = mtbt_pkg::OP_TICK;
            mtbt_pkg::KIND_FETCH:  decoded.op = mtbt_pkg::OP_FETCH;
        endcase
        decoded.in_range  = (int'(cmd.payload.bucket) < BUCKETS);
        decoded.bucket    = cmd.payload.bucket;
        decoded.fill_rate = cmd.payload.fill_rate;
        decoded.burst_cap = cmd.payload.burst_cap;
        decoded.request   = cmd.payload.request;
    end

    assign cmd.ready    = (count_reg != CNT_W'(mtbt_pkg::QUEUE_DEPTH));
    assign work.valid   = (count_reg != '0);
    assign work.payload = entry_reg[rd_ptr_reg];

    assign push = cmd.valid && cmd.ready;
    assign pop  = work.valid && work.ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(mtbt_pkg::QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(mtbt_pkg::QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/mtbt_back.sv @@
// Back end: bucket storage, operation sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none

module mtbt_back #(
    parameter int BUCKETS    = mtbt_pkg::BUCKETS_DEF,
    parameter int TOKEN_BITS = mtbt_pkg::TOKEN_BITS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mtbt_chan_if.sink   work,
    mtbt_chan_if.source rsp
);

    localparam int IDX_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NG     = (BUCKETS + mtbt_pkg::GROUP - 1) / mtbt_pkg::GROUP;
    localparam int SRCH_W = $clog2(NG * mtbt_pkg::GROUP);
    localparam int MIN_W  = (TOKEN_BITS > mtbt_pkg::FIELD_W) ? TOKEN_BITS : mtbt_pkg::FIELD_W;
    localparam int SUM_W  = MIN_W + 1;
    localparam int PRM_W  = 2 * mtbt_pkg::FIELD_W;
    localparam int BW     = mtbt_pkg::BUCKET_W;

    mtbt_pkg::state_t    state_reg, state_next;
    mtbt_pkg::work_t     item_reg, item_next;
    logic [BUCKETS-1:0]  used_reg, used_next;
    logic [IDX_W-1:0]    cnt_reg, cnt_next;
    logic [NG-1:0]       grp_free_reg, grp_free_c;
    logic [mtbt_pkg::GROUP_W-1:0] grp_low_reg [NG];
    logic [mtbt_pkg::GROUP_W-1:0] grp_low_c   [NG];
    mtbt_pkg::out_item_t hold_reg, out_reg, res_data;
    logic                out_valid_reg;

    logic                    pop, out_free, res_fire, out_load;
    logic                    rd_en, lvl_we, prm_we;
    logic [IDX_W-1:0]        rd_addr, lvl_waddr;
    logic [TOKEN_BITS-1:0]   lvl_wdata, lvl_rdata;
    logic [PRM_W-1:0]        prm_wdata, prm_rdata;
    logic [IDX_W-1:0]        w_addr, i_addr, free_idx;
    logic                    w_hit, i_hit, free_found;
    logic [SRCH_W-1:0]       pick;
    logic [NG*mtbt_pkg::GROUP-1:0] used_pad;
    logic [BW+IDX_W-1:0]     w_wide, i_wide, slot_wide;

    logic [SUM_W-1:0]      sum, lim, tmax, capped, clamped;
    logic [MIN_W-1:0]      lvl_x, req_x, grant;

    // slot address from the 6-bit bucket field
    assign w_wide = {{IDX_W{1'b0}}, work.payload.bucket};
    assign i_wide = {{IDX_W{1'b0}}, item_reg.bucket};
    assign w_addr = w_wide[IDX_W-1:0];
    assign i_addr = i_wide[IDX_W-1:0];
    assign w_hit  = work.payload.in_range && used_reg[w_addr];
    assign i_hit  = item_reg.in_range && used_reg[i_addr];

    assign pop      = work.valid && work.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    // per-group lowest free slot, registered while idle
    always_comb
    begin
        used_pad = '1;
        used_pad[BUCKETS-1:0] = used_reg;
        for (int g = 0; g < NG; g++)
        begin
            grp_free_c[g] = ~&used_pad[g*mtbt_pkg::GROUP +: mtbt_pkg::GROUP];
            grp_low_c[g]  = '0;
            for (int b = mtbt_pkg::GROUP - 1; b >= 0; b--)
            begin
                if (!used_pad[g*mtbt_pkg::GROUP + b])
                begin
                    grp_low_c[g] = mtbt_pkg::GROUP_W'(b);
                end
            end
        end
    end

    // lowest group with a free slot
    always_comb
    begin
        free_found = 1'b0;
        pick       = '0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (grp_free_reg[g])
            begin
                free_found = 1'b1;
                pick = SRCH_W'(g * mtbt_pkg::GROUP + int'(grp_low_reg[g]));
            end
        end
        free_idx  = pick[IDX_W-1:0];
        slot_wide = {{BW{1'b0}}, free_idx};
    end

    // refill with clamp at the burst cap and at the level width
    always_comb
    begin
        sum     = SUM_W'(lvl_rdata) + SUM_W'(prm_rdata[PRM_W-1:mtbt_pkg::FIELD_W]);
        lim     = SUM_W'(prm_rdata[mtbt_pkg::FIELD_W-1:0]);
        tmax    = SUM_W'({TOKEN_BITS{1'b1}});
        capped  = (sum > lim) ? lim : sum;
        clamped = (capped > tmax) ? tmax : capped;
    end

    // grant for a fetch
    always_comb
    begin
        lvl_x = MIN_W'(lvl_rdata);
        req_x = MIN_W'(item_reg.request);
        grant = (req_x < lvl_x) ? req_x : lvl_x;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        priority if (res_fire)
        begin
            state_next = out_free ? mtbt_pkg::S_IDLE : mtbt_pkg::S_HOLD;
        end
        else
        begin
            unique case (state_reg)
                mtbt_pkg::S_IDLE:
                begin
                    if (pop)
                    begin
                        unique case (work.payload.op)
                            mtbt_pkg::OP_CREATE: state_next = mtbt_pkg::S_CREATE;
                            mtbt_pkg::OP_DELETE: state_next = mtbt_pkg::S_IDLE;
                            mtbt_pkg::OP_TICK:   state_next = mtbt_pkg::S_TICK;
                            mtbt_pkg::OP_FETCH:  state_next = mtbt_pkg::S_FETCH;
                        endcase
                    end
                end
                mtbt_pkg::S_HOLD:
                begin
                    if (out_free)
                    begin
                        state_next = mtbt_pkg::S_IDLE;
                    end
                end
                mtbt_pkg::S_CREATE,
                mtbt_pkg::S_FETCH,
                mtbt_pkg::S_TICK:
                begin
                    state_next = state_reg;
                end
                default:
                begin
                    state_next = mtbt_pkg::S_IDLE;
                end
            endcase
        end
    end

    // outputs of the sequencer
    always_comb
    begin
        work.ready = 1'b0;
        item_next  = item_reg;
        used_next  = used_reg;
        cnt_next   = cnt_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        lvl_we     = 1'b0;
        lvl_waddr  = i_addr;
        lvl_wdata  = '0;
        prm_we     = 1'b0;
        prm_wdata  = {item_reg.fill_rate, item_reg.burst_cap};
        res_fire   = 1'b0;
        res_data.status  = mtbt_pkg::STAT_OK;
        res_data.slot    = item_reg.bucket;
        res_data.granted = '0;
        out_load   = 1'b0;

        unique case (state_reg)
            mtbt_pkg::S_IDLE:
            begin
                work.ready = 1'b1;
                if (work.valid)
                begin
                    item_next = work.payload;
                    res_data.slot = work.payload.bucket;
                    unique case (work.payload.op)
                        mtbt_pkg::OP_CREATE:
                        begin
                            res_fire = 1'b0;
                        end
                        mtbt_pkg::OP_DELETE:
                        begin
                            res_fire = 1'b1;
                            if (w_hit)
                            begin
                                used_next[w_addr] = 1'b0;
                            end
                            else
                            begin
                                res_data.status = mtbt_pkg::STAT_UNUSED;
                            end
                        end
                        mtbt_pkg::OP_TICK:
                        begin
                            rd_en    = 1'b1;
                            rd_addr  = '0;
                            cnt_next = '0;
                        end
                        mtbt_pkg::OP_FETCH:
                        begin
                            rd_en   = 1'b1;
                            rd_addr = w_addr;
                        end
                    endcase
                end
            end
            mtbt_pkg::S_CREATE:
            begin
                res_fire = 1'b1;
                if (free_found)
                begin
                    used_next[free_idx] = 1'b1;
                    lvl_we    = 1'b1;
                    lvl_waddr = free_idx;
                    lvl_wdata = '0;
                    prm_we    = 1'b1;
                    res_data.slot = slot_wide[BW-1:0];
                end
                else
                begin
                    res_data.status = mtbt_pkg::STAT_FULL;
                    res_data.slot   = '0;
                end
            end
            mtbt_pkg::S_FETCH:
            begin
                res_fire = 1'b1;
                // level is back; check use, then empty, then grant
                if (!i_hit)
                begin
                    res_data.status = mtbt_pkg::STAT_UNUSED;
                end
                else if (lvl_rdata == '0)
                begin
                    res_data.status = mtbt_pkg::STAT_EMPTY;
                end
                else
                begin
                    lvl_we    = 1'b1;
                    lvl_wdata = lvl_rdata - grant[TOKEN_BITS-1:0];
                    res_data.granted = grant[mtbt_pkg::FIELD_W-1:0];
                end
            end
            mtbt_pkg::S_TICK:
            begin
                // data for slot cnt is back; read the next slot
                lvl_waddr = cnt_reg;
                lvl_wdata = clamped[TOKEN_BITS-1:0];
                lvl_we    = used_reg[cnt_reg];
                rd_en     = (cnt_reg != IDX_W'(BUCKETS - 1));
                rd_addr   = cnt_reg + IDX_W'(1);
                cnt_next  = cnt_reg + IDX_W'(1);
                if (cnt_reg == IDX_W'(BUCKETS - 1))
                begin
                    res_fire = 1'b1;
                end
            end
            mtbt_pkg::S_HOLD:
            begin
                out_load = out_free;
            end
            default:
            begin
                work.ready = 1'b0;
            end
        endcase

        if (res_fire && out_free)
        begin
            out_load = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mtbt_pkg::S_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        cnt_reg  <= cnt_next;
        if (state_reg == mtbt_pkg::S_IDLE)
        begin
            grp_free_reg <= grp_free_c;
            grp_low_reg  <= grp_low_c;
        end
        if (res_fire && !out_free)
        begin
            hold_reg <= res_data;
        end
        if (out_load)
        begin
            out_reg <= (state_reg == mtbt_pkg::S_HOLD) ? hold_reg : res_data;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    mtbt_ram #(
        .WIDTH (TOKEN_BITS),
        .DEPTH (BUCKETS)
    ) u_level_ram (
        .clk   (clk),
        .we    (lvl_we),
        .waddr (lvl_waddr),
        .wdata (lvl_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (lvl_rdata)
    );

    mtbt_ram #(
        .WIDTH (PRM_W),
        .DEPTH (BUCKETS)
    ) u_param_ram (
        .clk   (clk),
        .we    (prm_we),
        .waddr (free_idx),
        .wdata (prm_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (prm_rdata)
    );

endmodule

`default_nettype wire

@@ hw/rtl/multi_token_bucket_table.sv @@
// Top level of the token bucket table: front end, request queue and back end.
//
//   channel  dir  payload                                         handshake
//   cmd      in   kind, bucket, fill_rate, burst_cap, request     valid/ready
//   rsp      out  status, slot, granted                           valid/ready
//
// One request is carried out at a time by the back end; a two-entry queue
// holds further requests and registers each one before the back end sees it.
// Delete completes when taken; create fills a free slot in S_CREATE; fetch reads
// the level RAM, then writes it after a grant; tick updates each slot in turn.
// Reset clears the slot-in-use bits; levels, rates and caps hold no reset value.
// A stalled result waits in the output register; the back end then holds its
// result and stops, while the front end keeps taking requests until the queue
// fills.
`timescale 1ns / 1ps
`default_nettype none

module multi_token_bucket_table #(
    parameter int BUCKETS    = mtbt_pkg::BUCKETS_DEF,
    parameter int TOKEN_BITS = mtbt_pkg::TOKEN_BITS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mtbt_chan_if.sink   cmd,
    mtbt_chan_if.source rsp
);

    mtbt_chan_if #(.payload_t(mtbt_pkg::work_t)) work_ch ();

    mtbt_front #(
        .BUCKETS (BUCKETS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .work  (work_ch)
    );

    mtbt_back #(
        .BUCKETS    (BUCKETS),
        .TOKEN_BITS (TOKEN_BITS)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .work  (work_ch),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

@@ hw/rtl/mtbt_checker.sv @@
// Port-level checks on the result channel of the token bucket table.
`timescale 1ns / 1ps
`default_nettype none

module mtbt_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                rsp_valid,
    input wire logic                rsp_ready,
    input wire mtbt_pkg::out_item_t rsp_payload
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_payload))
        else $error("result changed while stalled");

    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_payload.status == mtbt_pkg::STAT_FULL
        |-> rsp_payload.slot == '0 && rsp_payload.granted == '0)
        else $error("full result carries a slot or grant");

    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_payload.granted != '0 |-> rsp_payload.status == mtbt_pkg::STAT_OK)
        else $error("tokens granted with a failure status");

endmodule

bind multi_token_bucket_table mtbt_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);

`default_nettype wire
